[src/frustum_cull_distance_lod_defines.svh]
// Assertion macros used by the RTL of the culling block.
`ifndef FRUSTUM_CULL_DISTANCE_LOD_DEFINES_SVH
`define FRUSTUM_CULL_DISTANCE_LOD_DEFINES_SVH

// The condition holds at every rising clock edge outside reset.
`define FCDL_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fcdl assertion failed");

// The consequence holds in the cycle after the antecedent.
`define FCDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcdl assertion failed");

`endif

[src/fcdl_pkg.sv]
`default_nettype none
package fcdl_pkg;

  localparam int COORD_W        = 16;
  localparam int LOD_W          = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int PROD_W         = 32;
  localparam int CLIP_W         = 34;
  localparam int DIFF_W         = 17;
  localparam int DSQ_W          = 34;
  localparam int THR_W          = 16;
  localparam int TSQ_W          = 32;
  localparam int MAX_THRESHOLDS = 8;
  localparam int CNT_W          = 4;

  localparam logic [LOD_W-1:0] LOD_CULLED = 5'h1F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X     = 3'd0,
    REG_ROW_Y     = 3'd1,
    REG_ROW_Z     = 3'd2,
    REG_ROW_W     = 3'd3,
    REG_CAMERA    = 3'd4,
    REG_THR_LOW   = 3'd5,
    REG_THR_HIGH  = 3'd6,
    REG_THR_COUNT = 3'd7
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CLIP_W-1:0]  clip_t;

  // Signed 16-bit lane k of a packed 64-bit word.
  function automatic coord_t lane(input logic [63:0] packed_word, input int k);
    lane = coord_t'(packed_word[16*k +: 16]);
  endfunction

  function automatic logic [CLIP_W-1:0] abs_clip(input clip_t v);
    abs_clip = v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
  endfunction

endpackage
`default_nettype wire

[src/fcdl_if.sv]
`default_nettype none
interface fcdl_point_if;
  logic                          valid;
  logic                          ready;
  logic signed [fcdl_pkg::COORD_W-1:0] point_x;
  logic signed [fcdl_pkg::COORD_W-1:0] point_y;
  logic signed [fcdl_pkg::COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface fcdl_lod_if;
  logic                              valid;
  logic                              ready;
  logic signed [fcdl_pkg::LOD_W-1:0] lod_level;
  modport source (output valid, lod_level, input ready);
  modport sink (input valid, lod_level, output ready);
endinterface

interface fcdl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fcdl_pkg::CFG_IDX_W-1:0]      index;
  logic [fcdl_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/frustum_cull_distance_lod.sv]
// Frustum cull and distance LOD select for one query point per word.
// Channels: pt takes a word of point_x/y/z (signed Q8.8); lod returns one
// word of lod_level per point: -1 when the point lies outside the clip
// volume or clip w is zero, else the index of the first counted threshold above the
// camera distance, or the threshold count capped at eight when none is. cfg writes one
// register per word and is always ready; write it only while the block is idle.
// A point accepted on pt passes through the stage registers v1, v2, v3 and v4 in
// order; lod valid is driven by v4, and a stall on lod holds the word there.
// Throughput: one point per cycle while lod is ready. The four stages are the
// multipliers, the clip and distance adders, the frustum and threshold
// compares, and the level encoder that drives the output register.
// The distance is never square-rooted: a threshold t exceeds the floor
// distance exactly when the squared distance is below t*t.
// Reset clears the configuration registers and the stage valid bits. When lod stalls, each
// stage holds its word and the bubbles ahead of it fill; pt.ready falls only
// when every stage holds a word.
`default_nettype none
`include "frustum_cull_distance_lod_defines.svh"
module frustum_cull_distance_lod (
  input wire logic       clk,
  input wire logic       rst,
  fcdl_point_if.sink     pt,
  fcdl_lod_if.source     lod,
  fcdl_cfg_if.sink       cfg
);

  logic [63:0] row_x, row_y, row_z, row_w, thr_low, thr_high;
  logic [47:0] camera;
  logic [fcdl_pkg::CNT_W-1:0] thr_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x     <= '0;
      row_y     <= '0;
      row_z     <= '0;
      row_w     <= '0;
      camera    <= '0;
      thr_low   <= '0;
      thr_high  <= '0;
      thr_count <= '0;
    end else if (cfg.valid) begin
      unique case (fcdl_pkg::cfg_reg_t'(cfg.index))
        fcdl_pkg::REG_ROW_X:     row_x <= cfg.data;
        fcdl_pkg::REG_ROW_Y:     row_y <= cfg.data;
        fcdl_pkg::REG_ROW_Z:     row_z <= cfg.data;
        fcdl_pkg::REG_ROW_W:     row_w <= cfg.data;
        fcdl_pkg::REG_CAMERA:    camera <= cfg.data[47:0];
        fcdl_pkg::REG_THR_LOW:   thr_low <= cfg.data;
        fcdl_pkg::REG_THR_HIGH:  thr_high <= cfg.data;
        fcdl_pkg::REG_THR_COUNT: thr_count <= cfg.data[fcdl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared thresholds, recomputed each cycle from the stable registers.
  logic [fcdl_pkg::TSQ_W-1:0] thr_sq [fcdl_pkg::MAX_THRESHOLDS];
  logic [fcdl_pkg::CNT_W-1:0] count_sat;

  always_ff @(posedge clk) begin
    for (int i = 0; i < fcdl_pkg::MAX_THRESHOLDS; i++) begin
      logic [fcdl_pkg::THR_W-1:0] t;
      t = (i < 4) ? thr_low[16*(i%4) +: 16] : thr_high[16*(i%4) +: 16];
      thr_sq[i] <= t * t;
    end
    count_sat <= (thr_count > fcdl_pkg::CNT_W'(fcdl_pkg::MAX_THRESHOLDS))
               ? fcdl_pkg::CNT_W'(fcdl_pkg::MAX_THRESHOLDS) : thr_count;
  end

  // Stage handshakes: a stage advances when it is empty or the next one does.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || lod.ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign pt.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pt.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: products.
  fcdl_pkg::prod_t px_prod [4][3];
  fcdl_pkg::coord_t bias1 [4];
  logic [fcdl_pkg::DSQ_W-1:0] dsq1 [3];

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < 4; r++) begin
        logic [63:0] row;
        row = (r == 0) ? row_x : (r == 1) ? row_y : (r == 2) ? row_z : row_w;
        px_prod[r][0] <= fcdl_pkg::lane(row, 0) * pt.point_x;
        px_prod[r][1] <= fcdl_pkg::lane(row, 1) * pt.point_y;
        px_prod[r][2] <= fcdl_pkg::lane(row, 2) * pt.point_z;
        bias1[r]      <= fcdl_pkg::lane(row, 3);
      end
      for (int a = 0; a < 3; a++) begin
        logic signed [fcdl_pkg::DIFF_W-1:0] d;
        logic signed [fcdl_pkg::COORD_W-1:0] p;
        p = (a == 0) ? pt.point_x : (a == 1) ? pt.point_y : pt.point_z;
        d = fcdl_pkg::DIFF_W'(p) - fcdl_pkg::DIFF_W'(fcdl_pkg::lane({16'h0, camera}, a));
        dsq1[a] <= fcdl_pkg::DSQ_W'(d) * fcdl_pkg::DSQ_W'(d);
      end
    end
  end

  // Stage 2: clip coordinates and squared distance.
  fcdl_pkg::clip_t clip2 [4];
  logic [fcdl_pkg::DSQ_W-1:0] dsq2;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < 4; r++) begin
        clip2[r] <= fcdl_pkg::CLIP_W'(px_prod[r][0]) + fcdl_pkg::CLIP_W'(px_prod[r][1])
                  + fcdl_pkg::CLIP_W'(px_prod[r][2])
                  + (fcdl_pkg::CLIP_W'(bias1[r]) <<< 8);
      end
      dsq2 <= dsq1[0] + dsq1[1] + dsq1[2];
    end
  end

  // Stage 3: frustum test and threshold compares.
  logic culled3;
  logic [fcdl_pkg::MAX_THRESHOLDS-1:0] below3;
  logic [fcdl_pkg::CLIP_W-1:0] aw;

  assign aw = fcdl_pkg::abs_clip(clip2[3]);

  always_ff @(posedge clk) begin
    if (en3) begin
      culled3 <= (clip2[3] == '0) || (fcdl_pkg::abs_clip(clip2[0]) > aw)
              || (fcdl_pkg::abs_clip(clip2[1]) > aw) || (fcdl_pkg::abs_clip(clip2[2]) > aw);
      for (int i = 0; i < fcdl_pkg::MAX_THRESHOLDS; i++) begin
        below3[i] <= dsq2 < fcdl_pkg::DSQ_W'(thr_sq[i]);
      end
    end
  end

  // Stage 4: level encoder into the output register.
  logic [fcdl_pkg::LOD_W-1:0] level_next;

  always_comb begin
    level_next = fcdl_pkg::LOD_W'(count_sat);
    for (int i = fcdl_pkg::MAX_THRESHOLDS - 1; i >= 0; i--) begin
      if (below3[i] && (fcdl_pkg::CNT_W'(i) < count_sat)) begin
        level_next = fcdl_pkg::LOD_W'(i);
      end
    end
    if (culled3) begin
      level_next = fcdl_pkg::LOD_CULLED;
    end
  end

  logic [fcdl_pkg::LOD_W-1:0] level4;

  always_ff @(posedge clk) begin
    if (en4) begin
      level4 <= level_next;
    end
  end

  assign lod.valid     = v4;
  assign lod.lod_level = level4;

  `FCDL_ASSERT_ALWAYS(a_level_range, !v4 || level4 == fcdl_pkg::LOD_CULLED || level4 <= fcdl_pkg::LOD_W'(fcdl_pkg::MAX_THRESHOLDS))
  `FCDL_ASSERT_NEXT(a_stall_keeps_s1, v1 && !en1, v1)
  `FCDL_ASSERT_NEXT(a_culled_out, v3 && en4 && culled3, v4 && level4 == fcdl_pkg::LOD_CULLED)

endmodule
`default_nettype wire

[tb/sv/lod_checker.sv]
`timescale 1ns / 100ps
module lod_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  fcdl_point_if      pt,
  fcdl_lod_if        lod,
  fcdl_cfg_if        cfg,
  output int         fail_count,
  output int         pending_count
);

  logic [63:0] row_x, row_y, row_z, row_w, thr_lo, thr_hi;
  logic [47:0] cam;
  logic [3:0]  thr_cnt;
  logic signed [fcdl_pkg::LOD_W-1:0] lod_expected_q[$];

  function automatic logic signed [63:0] sx(input logic [15:0] v);
    sx = {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] clip_of(input logic [63:0] r,
      input logic signed [63:0] px, input logic signed [63:0] py,
      input logic signed [63:0] pz);
    clip_of = sx(r[15:0]) * px + sx(r[31:16]) * py + sx(r[47:32]) * pz
            + sx(r[63:48]) * 256;
  endfunction

  function automatic logic signed [63:0] mag(input logic signed [63:0] v);
    mag = v < 0 ? -v : v;
  endfunction

  function automatic logic signed [fcdl_pkg::LOD_W-1:0] predict_lod(input logic [15:0] x,
      input logic [15:0] y, input logic [15:0] z);
    logic signed [63:0] px, py, pz, w, dx, dy, dz;
    logic [63:0] dsq, dist_fl, r, t, thr;
    int unsigned n, lvl;
    px = sx(x); py = sx(y); pz = sx(z);
    w = clip_of(row_w, px, py, pz);
    if (w == 0 || mag(clip_of(row_x, px, py, pz)) > mag(w) ||
        mag(clip_of(row_y, px, py, pz)) > mag(w) ||
        mag(clip_of(row_z, px, py, pz)) > mag(w)) return fcdl_pkg::LOD_CULLED;
    dx = px - sx(cam[15:0]); dy = py - sx(cam[31:16]); dz = pz - sx(cam[47:32]);
    dsq = dx * dx + dy * dy + dz * dz;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= dsq) r = t;
    end
    dist_fl = r > 65535 ? 65535 : r;
    n = thr_cnt > fcdl_pkg::MAX_THRESHOLDS ? fcdl_pkg::MAX_THRESHOLDS : thr_cnt;
    lvl = n;
    for (int i = n - 1; i >= 0; i--) begin
      thr = i < 4 ? (thr_lo >> (16 * i)) & 64'hFFFF : (thr_hi >> (16 * (i - 4))) & 64'hFFFF;
      if (thr > dist_fl) lvl = i;
    end
    predict_lod = fcdl_pkg::LOD_W'(lvl);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      row_x <= '0; row_y <= '0; row_z <= '0; row_w <= '0;
      cam <= '0; thr_lo <= '0; thr_hi <= '0; thr_cnt <= '0;
      fail_count <= 0;
      lod_expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (fcdl_pkg::cfg_reg_t'(cfg.index))
          fcdl_pkg::REG_ROW_X:     row_x <= cfg.data;
          fcdl_pkg::REG_ROW_Y:     row_y <= cfg.data;
          fcdl_pkg::REG_ROW_Z:     row_z <= cfg.data;
          fcdl_pkg::REG_ROW_W:     row_w <= cfg.data;
          fcdl_pkg::REG_CAMERA:    cam <= cfg.data[47:0];
          fcdl_pkg::REG_THR_LOW:   thr_lo <= cfg.data;
          fcdl_pkg::REG_THR_HIGH:  thr_hi <= cfg.data;
          fcdl_pkg::REG_THR_COUNT: thr_cnt <= cfg.data[3:0];
          default: ;
        endcase
      end
      if (pt.valid && pt.ready)
        lod_expected_q.push_back(predict_lod(pt.point_x, pt.point_y, pt.point_z));
      if (lod.valid && lod.ready) begin
        if (lod_expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected lod word %0d", lod.lod_level);
          fail_count <= fail_count + 1;
        end else begin
          if (lod.lod_level !== lod_expected_q[0]) begin
            if (fail_count < 10)
              $display("lod mismatch: expected %0d got %0d", lod_expected_q[0],
                       lod.lod_level);
            fail_count <= fail_count + 1;
          end
          void'(lod_expected_q.pop_front());
        end
      end
    end
  end

  assign pending_count = lod_expected_q.size();
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  logic clk, rst;
  int   fail_count, pending_count, cycle_count;
  bit   rx_hold;

  fcdl_point_if pt();
  fcdl_lod_if   lod();
  fcdl_cfg_if   cfg();

  frustum_cull_distance_lod dut (.clk(clk), .rst(rst), .pt(pt), .lod(lod), .cfg(cfg));
  lod_checker chk (.clk(clk), .rst(rst), .pt(pt), .lod(lod), .cfg(cfg),
                   .fail_count(fail_count), .pending_count(pending_count));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    gap_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
  endfunction

  // Identity-like scale: 1.0 in Q4.12 on the diagonal.
  function automatic logic [63:0] row_word(input int k, input logic [15:0] s);
    row_word = 64'(s) << (16 * k);
  endfunction

  task automatic write_reg(input fcdl_pkg::cfg_reg_t idx, input logic [63:0] val);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
      input logic [15:0] z);
    pt.valid <= 1; pt.point_x <= x; pt.point_y <= y; pt.point_z <= z;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
  endtask

  task automatic send_random(input int n, input bit narrow);
    int g;
    for (int i = 0; i < n; i++) begin
      if (narrow)
        send_point(16'($signed($urandom_range(0, 1023)) - 512),
                   16'($signed($urandom_range(0, 1023)) - 512),
                   16'($signed($urandom_range(0, 1023)) - 512));
      else
        send_point(16'($urandom), 16'($urandom), 16'($urandom));
      g = gap_len();
      if (g > 0) begin
        pt.valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    pt.valid <= 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(fcdl_pkg::REG_ROW_X, {$urandom, $urandom} & 64'h0000_00FF_00FF_0FFF);
    write_reg(fcdl_pkg::REG_ROW_Y, {$urandom, $urandom} & 64'h0000_00FF_0FFF_00FF);
    write_reg(fcdl_pkg::REG_ROW_Z, {$urandom, $urandom} & 64'h0000_0FFF_00FF_00FF);
    write_reg(fcdl_pkg::REG_ROW_W, row_word(3, 16'($urandom_range(1, 16'h7FFF))) |
              ({$urandom, $urandom} & 64'hFFFF_00FF_00FF_00FF));
    write_reg(fcdl_pkg::REG_CAMERA, 64'({16'($urandom_range(0, 1023) - 512),
                                         16'($urandom_range(0, 1023) - 512),
                                         16'($urandom_range(0, 1023) - 512)}));
    write_reg(fcdl_pkg::REG_THR_LOW,
              {16'($urandom_range(600, 800)), 16'($urandom_range(400, 599)),
               16'($urandom_range(200, 399)), 16'($urandom_range(0, 199))});
    write_reg(fcdl_pkg::REG_THR_HIGH, {$urandom, $urandom});
    write_reg(fcdl_pkg::REG_THR_COUNT, 64'($urandom_range(0, 15)));
  endtask

  always @(posedge clk) begin
    if (rst) rx_hold <= 0;
    else if ($urandom_range(0, 99) < 15) rx_hold <= ~rx_hold;
    lod.ready <= ~rx_hold | ($urandom_range(0, 3) == 0);
    cycle_count <= rst ? 0 : cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1;
    pt.valid = 0; pt.point_x = 0; pt.point_y = 0; pt.point_z = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    lod.ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    // Reset registers: w is zero, so everything is culled.
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h8000, 16'hFFFF);
    pt.valid <= 0;
    drain();
    // Wide frustum with w near 8.0 and extreme thresholds.
    write_reg(fcdl_pkg::REG_ROW_X, row_word(0, 16'h1000));
    write_reg(fcdl_pkg::REG_ROW_Y, row_word(1, 16'h1000));
    write_reg(fcdl_pkg::REG_ROW_Z, row_word(2, 16'h1000));
    write_reg(fcdl_pkg::REG_ROW_W, row_word(3, 16'h7FFF));
    write_reg(fcdl_pkg::REG_CAMERA, 64'({16'h8000, 16'h7FFF, 16'h0000}));
    write_reg(fcdl_pkg::REG_THR_LOW, {16'hFFFF, 16'h0100, 16'h0010, 16'h0000});
    write_reg(fcdl_pkg::REG_THR_HIGH, {16'h0000, 16'hFFFF, 16'h8000, 16'h0001});
    write_reg(fcdl_pkg::REG_THR_COUNT, 64'd15);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h0010, 16'h7FFF, 16'h0000);
    send_point(16'h8000, 16'h7FFF, 16'h0000);
    send_point(16'h7FFF, 16'h8000, 16'h0001);
    pt.valid <= 0;
    drain();
    write_reg(fcdl_pkg::REG_THR_COUNT, 64'd0);
    send_point(16'h0100, 16'hFF00, 16'h0080);
    pt.valid <= 0;
    drain();
    write_reg(fcdl_pkg::REG_THR_COUNT, 64'd8);
    write_reg(fcdl_pkg::REG_ROW_W, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(16'h0001, 16'h0000, 16'hFFFF);
    send_point(16'h1234, 16'hEDCB, 16'h0000);
    pt.valid <= 0;
    drain();
    // Random phases; the drain before each reconfiguration doubles as the
    // sender pause until all outstanding words have returned.
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      send_random(180, 1);
      send_random(20, 0);
      drain();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[frustum_cull_distance_lod.f]
+incdir+src
src/fcdl_pkg.sv
src/fcdl_if.sv
src/frustum_cull_distance_lod.sv
tb/sv/lod_checker.sv
tb/sv/tb_top.sv
